@@ hw/rtl/biu_pkg.sv @@
// ---------------------------------------------------------------------------
// biu_pkg
// Shared types and constants of the bicubic upscaler.
// ---------------------------------------------------------------------------
package biu_pkg;

	// configuration register indices
	localparam logic [1:0] REG_SRC_ROWS = 2'd0;
	localparam logic [1:0] REG_SRC_COLS = 2'd1;
	localparam logic [1:0] REG_STEP_X   = 2'd2;
	localparam logic [1:0] REG_STEP_Y   = 2'd3;

	localparam int CFG_W  = 20;
	localparam int STEP_W = 20;
	localparam int PIX_W  = 17;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ROW,
		ST_COL,
		ST_DONE
	} seq_state_t;

	// cubic unit control
	typedef struct packed {
		logic start;
		logic is_col;
	} cub_ctrl_t;

endpackage

@@ hw/rtl/biu_ram.sv @@
// ---------------------------------------------------------------------------
// biu_ram
// Generic single-port-write, registered-read RAM.
// ---------------------------------------------------------------------------
module biu_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/biu_cubic.sv @@
// ---------------------------------------------------------------------------
// biu_cubic
// Multi-cycle Catmull-Rom cubic: one multiply per cycle, registered between.
// ---------------------------------------------------------------------------
module biu_cubic #(
	parameter int IN_W = 22
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  biu_pkg::cub_ctrl_t     ctrl,
	input  logic signed [IN_W-1:0] p0,
	input  logic signed [IN_W-1:0] p1,
	input  logic signed [IN_W-1:0] p2,
	input  logic signed [IN_W-1:0] p3,
	input  logic [15:0]            t,
	output logic                   done,
	output logic signed [IN_W+3:0] res
);

	// coefficient width: |b| <= 12*max, |a| <= 8*max
	localparam int CW = IN_W + 4;
	localparam int HW = CW + 18;
	localparam int MW = HW + 18;

	logic signed [CW-1:0] a_q, b_q, c_q, p1_q;
	logic signed [MW-1:0] prod_q;
	logic [16:0] t_q;
	logic        col_q;
	logic [2:0]  phase_q;

	logic signed [CW-1:0] a_n, b_n, c_n;
	logic signed [HW-1:0] h_n;
	logic signed [HW-1:0] mul_a;
	logic signed [17:0]   mul_b;
	logic signed [IN_W+23:0] full_v;
	logic signed [IN_W+3:0]  rnd_v;

	assign a_n = CW'(3 * (CW'(p1) - CW'(p2)) + CW'(p3) - CW'(p0));
	assign b_n = CW'(2 * CW'(p0) - 5 * CW'(p1) + 4 * CW'(p2) - CW'(p3));
	assign c_n = CW'(p2) - CW'(p0);

	// floored product of the previous phase
	assign h_n = HW'(prod_q >>> 16);

	// multiplier operands per phase: a*t, then (b<<16+a*t)*t, then (c<<16+h)*t
	always_comb begin
		case (phase_q)
			3'd1: mul_a = HW'(a_q);
			3'd2: mul_a = (HW'(b_q) <<< 16) + HW'(prod_q);
			3'd3: mul_a = (HW'(c_q) <<< 16) + h_n;
			default: mul_a = '0;
		endcase
		mul_b = signed'({1'b0, t_q});
	end

	// final sum and rounding (row to Q.8, column to Q.4)
	always_comb begin
		full_v = ((IN_W+24)'(p1_q) <<< 17) + (IN_W+24)'(h_n);
		if (col_q) begin
			rnd_v = (IN_W+4)'((full_v + (IN_W+24)'(1 <<< 20)) >>> 21);
		end else begin
			rnd_v = (IN_W+4)'((full_v + (IN_W+24)'(1 <<< 8)) >>> 9);
		end
	end

	// sequencing of the shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 3'd0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (phase_q)
				3'd0: if (ctrl.start) phase_q <= 3'd1;
				3'd1: phase_q <= 3'd2;
				3'd2: phase_q <= 3'd3;
				3'd3: phase_q <= 3'd4;
				3'd4: begin
					phase_q <= 3'd0;
					done    <= 1'b1;
				end
				default: phase_q <= 3'd0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (phase_q == 3'd0 && ctrl.start) begin
			a_q   <= a_n;
			b_q   <= b_n;
			c_q   <= c_n;
			p1_q  <= CW'(p1);
			t_q   <= {1'b0, t};
			col_q <= ctrl.is_col;
		end
		if (phase_q == 3'd1 || phase_q == 3'd2 || phase_q == 3'd3) begin
			prod_q <= mul_a * mul_b;
		end
		if (phase_q == 3'd4) begin
			res <= rnd_v;
		end
	end

endmodule

@@ hw/rtl/bicubic_image_upscaler_core.sv @@
// ---------------------------------------------------------------------------
// bicubic_image_upscaler_core
// Catmull-Rom upscaler with a frame memory and a shared cubic unit.
// ---------------------------------------------------------------------------
// channel  | ports                                             | handshake
// input    | kind sample_row sample_col sample_value out_x out_y | start/busy
// result   | pixel_value pixel_x pixel_y                       | done strobe
// config   | cfg_we cfg_index cfg_data                         | write enable
//
// a load is taken without raising busy, loads can follow back to back
// a pixel request holds busy over, per row, four frame reads (registered read
// data) and the row cubic on the shared cubic unit, then the column cubic and
// the done strobe register; the result strobe comes in the first cycle after
// busy falls, when a new request may already be taken; the result side cannot
// stall. No clearing pass after reset: the user must read frame entries only
// once written; the block does not check this
module bicubic_image_upscaler_core #(
	parameter int MAX_SRC_SIDE = 16,
	parameter int MAX_DST_SIDE = 64,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic kind,
	input  logic [$clog2(MAX_SRC_SIDE)-1:0] sample_row,
	input  logic [$clog2(MAX_SRC_SIDE)-1:0] sample_col,
	input  logic signed [SAMPLE_BITS-1:0]   sample_value,
	input  logic [$clog2(MAX_DST_SIDE)-1:0] out_x,
	input  logic [$clog2(MAX_DST_SIDE)-1:0] out_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [biu_pkg::CFG_W-1:0] cfg_data,
	output logic done,
	output logic signed [biu_pkg::PIX_W-1:0] pixel_value,
	output logic [$clog2(MAX_DST_SIDE)-1:0] pixel_x,
	output logic [$clog2(MAX_DST_SIDE)-1:0] pixel_y
);

	localparam int SW = $clog2(MAX_SRC_SIDE);
	localparam int DW = $clog2(MAX_DST_SIDE);
	localparam int AW = 2 * SW;
	localparam int PW = DW + biu_pkg::STEP_W;
	localparam int IW = PW - 16;
	localparam int RW = SAMPLE_BITS + 10;
	localparam int OW = RW + 4;
	localparam int SZW = SW + 1;

	logic [4:0] rows_q, cols_q;
	logic [biu_pkg::STEP_W-1:0] stepx_q, stepy_q;

	biu_pkg::seq_state_t state_q, state_n;
	logic [PW-1:0] px_q, py_q;
	logic [DW-1:0] ox_q, oy_q;
	logic [SW-1:0] rmax_q, cmax_q;
	logic [1:0] dy_q, dx_q;
	logic       rd_v_s1;
	logic [1:0] rd_dx_s1;
	logic signed [RW-1:0] win_q [4];
	logic signed [RW-1:0] colv_q [4];
	logic [2:0] nread_q;
	logic cub_busy_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	biu_pkg::cub_ctrl_t cctl;
	logic cub_done;
	logic signed [RW+3:0] cub_res;
	logic signed [RW-1:0] cp0, cp1, cp2, cp3;
	logic [15:0] ct;
	logic signed [SW+IW+2:0] rr_raw, cc_raw;
	logic [SW-1:0] rr, cc;
	logic accept;
	logic [SZW-1:0] rsat, csat;

	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 5'd8;
			cols_q  <= 5'd8;
			stepx_q <= biu_pkg::STEP_W'(11763);
			stepy_q <= biu_pkg::STEP_W'(11763);
		end else if (cfg_we) begin
			case (cfg_index)
				biu_pkg::REG_SRC_ROWS: rows_q  <= cfg_data[4:0];
				biu_pkg::REG_SRC_COLS: cols_q  <= cfg_data[4:0];
				biu_pkg::REG_STEP_X:   stepx_q <= cfg_data;
				biu_pkg::REG_STEP_Y:   stepy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame size saturated to 1..MAX_SRC_SIDE
	always_comb begin
		if (rows_q == 5'd0) rsat = SZW'(1);
		else if (32'(rows_q) > MAX_SRC_SIDE) rsat = SZW'(MAX_SRC_SIDE);
		else rsat = SZW'(rows_q);
		if (cols_q == 5'd0) csat = SZW'(1);
		else if (32'(cols_q) > MAX_SRC_SIDE) csat = SZW'(MAX_SRC_SIDE);
		else csat = SZW'(cols_q);
	end

	// neighbour address with edge clamping
	always_comb begin
		rr_raw = (SW+IW+3)'(py_q[PW-1:16]) + (SW+IW+3)'(dy_q) - (SW+IW+3)'(1);
		cc_raw = (SW+IW+3)'(px_q[PW-1:16]) + (SW+IW+3)'(dx_q) - (SW+IW+3)'(1);
		if (rr_raw < 0) rr = '0;
		else if (rr_raw > (SW+IW+3)'(rmax_q)) rr = rmax_q;
		else rr = rr_raw[SW-1:0];
		if (cc_raw < 0) cc = '0;
		else if (cc_raw > (SW+IW+3)'(cmax_q)) cc = cmax_q;
		else cc = cc_raw[SW-1:0];
	end

	assign ram_we    = accept && !kind;
	assign ram_waddr = {sample_row, sample_col};
	assign ram_raddr = {rr, cc};

	biu_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SRC_SIDE * MAX_SRC_SIDE)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(sample_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// cubic operand selection: rows from the window, column from row results
	always_comb begin
		cctl.start  = 1'b0;
		cctl.is_col = (state_q == biu_pkg::ST_COL);
		if (state_q == biu_pkg::ST_COL) begin
			cp0 = colv_q[0]; cp1 = colv_q[1]; cp2 = colv_q[2]; cp3 = colv_q[3];
			ct  = py_q[15:0];
		end else begin
			cp0 = win_q[0]; cp1 = win_q[1];
			cp2 = win_q[2]; cp3 = win_q[3];
			ct  = px_q[15:0];
		end
		if ((state_q == biu_pkg::ST_READ && nread_q == 3'd4) ||
			(state_q == biu_pkg::ST_COL && !cub_busy_q)) begin
			cctl.start = 1'b1;
		end
	end

	biu_cubic #(.IN_W(RW)) u_cubic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cctl),
		.p0    (cp0),
		.p1    (cp1),
		.p2    (cp2),
		.p3    (cp3),
		.t     (ct),
		.done  (cub_done),
		.res   (cub_res)
	);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			biu_pkg::ST_IDLE: if (accept && kind) state_n = biu_pkg::ST_READ;
			biu_pkg::ST_READ: if (nread_q == 3'd4) state_n = biu_pkg::ST_ROW;
			biu_pkg::ST_ROW: begin
				if (cub_done) begin
					state_n = (dy_q == 2'd3) ? biu_pkg::ST_COL : biu_pkg::ST_READ;
				end
			end
			biu_pkg::ST_COL: if (cub_done) state_n = biu_pkg::ST_DONE;
			biu_pkg::ST_DONE: state_n = biu_pkg::ST_IDLE;
			default: state_n = biu_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != biu_pkg::ST_IDLE);
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= biu_pkg::ST_IDLE;
			dy_q       <= '0;
			dx_q       <= '0;
			nread_q    <= '0;
			rd_v_s1    <= 1'b0;
			cub_busy_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			state_q <= state_n;
			done    <= 1'b0;
			rd_v_s1 <= 1'b0;
			if (cctl.start) cub_busy_q <= 1'b1;
			if (cub_done)   cub_busy_q <= 1'b0;
			case (state_q)
				biu_pkg::ST_IDLE: begin
					dy_q <= '0; dx_q <= '0; nread_q <= '0;
				end
				biu_pkg::ST_READ: begin
					if (nread_q != 3'd4) begin
						if (!(dx_q == 2'd3 && rd_v_s1 && rd_dx_s1 == 2'd3) &&
							nread_q + 3'(rd_v_s1) < 3'd4) begin
							rd_v_s1 <= 1'b1;
							dx_q    <= dx_q + 2'd1;
						end
						if (rd_v_s1) nread_q <= nread_q + 3'd1;
					end
				end
				biu_pkg::ST_ROW: begin
					nread_q <= '0;
					dx_q    <= '0;
					if (cub_done) dy_q <= dy_q + 2'd1;
				end
				biu_pkg::ST_COL: ;
				biu_pkg::ST_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_dx_s1 <= dx_q;
		if (accept && kind) begin
			px_q   <= PW'(out_x) * PW'(stepx_q);
			py_q   <= PW'(out_y) * PW'(stepy_q);
			ox_q   <= out_x;
			oy_q   <= out_y;
			rmax_q <= SW'(rsat - SZW'(1));
			cmax_q <= SW'(csat - SZW'(1));
		end
		if (rd_v_s1) win_q[rd_dx_s1] <= RW'(signed'(ram_rdata));
		if (state_q == biu_pkg::ST_ROW && cub_done) colv_q[dy_q] <= RW'(cub_res);
		if (state_q == biu_pkg::ST_COL && cub_done) begin
			if (cub_res < -(RW+4)'(65536)) pixel_value <= -biu_pkg::PIX_W'(65536);
			else if (cub_res > (RW+4)'(65535)) pixel_value <= biu_pkg::PIX_W'(65535);
			else pixel_value <= biu_pkg::PIX_W'(cub_res);
			pixel_x <= ox_q;
			pixel_y <= oy_q;
		end
	end

endmodule

@@ bench/bicubic_image_upscaler_core_tb.sv @@
// ---------------------------------------------------------------------------
// bicubic_image_upscaler_core_tb
// Loads source frames and requests output pixels, each pixel checked field by
// field against an in-bench fixed-point Catmull-Rom predictor.
// ---------------------------------------------------------------------------
module bicubic_image_upscaler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE = 16;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [3:0] sample_row = '0;
	logic [3:0] sample_col = '0;
	logic signed [11:0] sample_value = '0;
	logic [5:0] out_x = '0;
	logic [5:0] out_y = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [biu_pkg::CFG_W-1:0] cfg_data = '0;
	logic done;
	logic signed [biu_pkg::PIX_W-1:0] pixel_value;
	logic [5:0] pixel_x;
	logic [5:0] pixel_y;

	bicubic_image_upscaler_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic signed [16:0] value;
		logic [5:0] x;
		logic [5:0] y;
	} pixel_t;

	// predictor state
	logic [4:0] rows_q = 5'd8, cols_q = 5'd8;
	logic [19:0] stepx_q = 20'd11763, stepy_q = 20'd11763;
	logic signed [11:0] frame_mem [SIDE*SIDE];
	bit written [SIDE*SIDE];
	pixel_t pending_pixels [$];
	int errors = 0;
	int mismatches = 0;
	longint cycles = 0;
	int idle_pct = 0;

	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
			longint t);
		longint a, b, c, h;
		a = 3 * (p1 - p2) + p3 - p0;
		b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c = p2 - p0;
		h = fdiv((b * 65536 + a * t) * t, 16);
		h = fdiv((c * 65536 + h) * t, 16);
		return p1 * 131072 + h;
	endfunction

	function automatic int side_of(logic [4:0] v);
		if (v < 1) return 1;
		if (v > SIDE) return SIDE;
		return v;
	endfunction

	function automatic int clampi(longint v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic pixel_t interpolate(logic [5:0] ox, logic [5:0] oy);
		pixel_t r;
		longint px, py, fx, fy, v;
		longint colv [4];
		longint rv [4];
		int ix, iy, rr;
		px = longint'(ox) * stepx_q;
		py = longint'(oy) * stepy_q;
		ix = int'(px >> 16);
		iy = int'(py >> 16);
		fx = px & 16'hFFFF;
		fy = py & 16'hFFFF;
		for (int dy = 0; dy < 4; dy++) begin
			rr = clampi(iy + dy - 1, side_of(rows_q) - 1);
			for (int dx = 0; dx < 4; dx++)
				rv[dx] = frame_mem[rr*SIDE + clampi(ix + dx - 1, side_of(cols_q) - 1)];
			colv[dy] = fdiv(catmull(rv[0], rv[1], rv[2], rv[3], fx) + 256, 9);
		end
		v = fdiv(catmull(colv[0], colv[1], colv[2], colv[3], fy) + (64'sd1 << 20), 21);
		if (v < -65536) v = -65536;
		if (v > 65535) v = 65535;
		r.value = v[16:0];
		r.x = ox;
		r.y = oy;
		return r;
	endfunction

	// frame window actually touched by a request must be written
	function automatic bit window_ready(logic [5:0] ox, logic [5:0] oy);
		longint px, py;
		int ix, iy;
		px = longint'(ox) * stepx_q;
		py = longint'(oy) * stepy_q;
		ix = int'(px >> 16);
		iy = int'(py >> 16);
		for (int dy = 0; dy < 4; dy++)
			for (int dx = 0; dx < 4; dx++)
				if (!written[clampi(iy + dy - 1, side_of(rows_q) - 1)*SIDE +
						clampi(ix + dx - 1, side_of(cols_q) - 1)])
					return 0;
		return 1;
	endfunction

	// result checker and cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bicubic_image_upscaler_core_tb: FAIL");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected pixel %0d", pixel_value);
			end else begin
				pixel_t e;
				e = pending_pixels.pop_front();
				if (e.value !== pixel_value || e.x !== pixel_x || e.y !== pixel_y) begin
					errors++;
					if (mismatches++ < 10)
						$display("pixel mismatch: exp %0d (%0d,%0d) got %0d (%0d,%0d)",
							e.value, e.x, e.y, pixel_value, pixel_x, pixel_y);
				end
			end
		end
	end

	// sender idle cycles, start dropped while idling
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// one request through the start/busy handshake, busy looked at mid-cycle
	task automatic send(logic k, logic [3:0] r, logic [3:0] c, logic [11:0] s,
			logic [5:0] ox, logic [5:0] oy);
		idle_gap();
		start <= 1'b1;
		kind <= k;
		sample_row <= r;
		sample_col <= c;
		sample_value <= s;
		out_x <= ox;
		out_y <= oy;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (k == KIND_LOAD) begin
			frame_mem[r*SIDE + c] = s;
			written[r*SIDE + c] = 1;
		end else begin
			pending_pixels.push_back(interpolate(ox, oy));
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			biu_pkg::REG_SRC_ROWS: rows_q = d[4:0];
			biu_pkg::REG_SRC_COLS: cols_q = d[4:0];
			biu_pkg::REG_STEP_X: stepx_q = d;
			default: stepy_q = d;
		endcase
	endtask

	task automatic fill_frame(bit extreme);
		logic [11:0] s;
		for (int i = 0; i < SIDE*SIDE; i++) begin
			s = extreme ? (i[0] ? 12'h7FF : 12'h800) : 12'($urandom);
			send(KIND_LOAD, i[7:4], i[3:0], s, 6'd0, 6'd0);
		end
	endtask

	task automatic random_pixels(int n);
		logic [5:0] ox, oy;
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(3) == 0) begin
				send(KIND_LOAD, 4'($urandom), 4'($urandom), 12'($urandom), 6'($urandom),
					6'($urandom));
			end else begin
				ox = 6'($urandom);
				oy = 6'($urandom);
				if (window_ready(ox, oy)) begin
					send(KIND_PIXEL, 4'($urandom), 4'($urandom), 12'($urandom), ox, oy);
					sent++;
				end
			end
		end
	endtask

	typedef struct {
		logic [5:0] ox;
		logic [5:0] oy;
		bit known;
		logic signed [16:0] value;
	} pixel_row_t;

	// directed rows: corners and extremes on an alternating extreme frame
	pixel_row_t directed [8] = '{
		'{6'd0, 6'd0, 1'b1, -17'sd32768},
		'{6'd63, 6'd63, 1'b0, '0},
		'{6'd0, 6'd63, 1'b0, '0},
		'{6'd63, 6'd0, 1'b0, '0},
		'{6'd1, 6'd1, 1'b0, '0},
		'{6'd21, 6'd42, 1'b0, '0},
		'{6'd5, 6'd9, 1'b0, '0},
		'{6'd44, 6'd3, 1'b0, '0}
	};

	initial begin
		pixel_t e;
		for (int i = 0; i < SIDE*SIDE; i++) begin
			frame_mem[i] = '0;
			written[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme frame at reset settings
		fill_frame(1);
		foreach (directed[i]) begin
			send(KIND_PIXEL, '0, '0, '0, directed[i].ox, directed[i].oy);
			if (directed[i].known) begin
				e = pending_pixels.pop_back();
				e.value = directed[i].value;
				pending_pixels.push_back(e);
			end
		end
		drain();
		// saturated frame sizes and extreme steps
		write_reg(biu_pkg::REG_SRC_ROWS, 20'd0);
		write_reg(biu_pkg::REG_SRC_COLS, 20'd31);
		write_reg(biu_pkg::REG_STEP_X, 20'hFFFFF);
		write_reg(biu_pkg::REG_STEP_Y, 20'd0);
		send(KIND_PIXEL, '0, '0, '0, 6'd63, 6'd63);
		send(KIND_PIXEL, '0, '0, '0, 6'd7, 6'd2);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 88 : (ph == 3) ? 13 : 0;
			case (ph)
				0: begin
					write_reg(biu_pkg::REG_SRC_ROWS, 20'd2);
					write_reg(biu_pkg::REG_SRC_COLS, 20'd16);
					write_reg(biu_pkg::REG_STEP_X, 20'd983040);
					write_reg(biu_pkg::REG_STEP_Y, 20'd32768);
				end
				1: begin
					write_reg(biu_pkg::REG_SRC_ROWS, 20'd16);
					write_reg(biu_pkg::REG_SRC_COLS, 20'd2);
					write_reg(biu_pkg::REG_STEP_X, 20'd16384);
					write_reg(biu_pkg::REG_STEP_Y, 20'd983040);
				end
				default: begin
					write_reg(biu_pkg::REG_SRC_ROWS, 20'($urandom_range(16, 2)));
					write_reg(biu_pkg::REG_SRC_COLS, 20'($urandom_range(16, 2)));
					write_reg(biu_pkg::REG_STEP_X, 20'($urandom_range(983040)));
					write_reg(biu_pkg::REG_STEP_Y, 20'($urandom_range(65535)));
				end
			endcase
			random_pixels(60);
			drain();
		end

		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("bicubic_image_upscaler_core_tb: PASS");
		end else begin
			$display("bicubic_image_upscaler_core_tb: FAIL");
		end
		$finish;
	end
endmodule
